FILE: design/bracketed_decimal_parser_core_defines.svh
// Assertion macros for the bracketed decimal parser core.
// Included by the top level; no other dependencies.
`ifndef BRACKETED_DECIMAL_PARSER_CORE_DEFINES_SVH
`define BRACKETED_DECIMAL_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge, ignored while reset is low.
`define BDP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bdp assertion failed");

// Property checked on every rising edge, reset included.
`define BDP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bdp assertion failed");

`else

`define BDP_ASSERT(label, clk, rst_n, prop)
`define BDP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: design/bdp_pkg.sv
// Shared types and constants of the bracketed decimal parser.
// No dependencies; used by bdp_step and bracketed_decimal_parser_core.
package bdp_pkg;

    localparam int MAX_CHARS     = 40;
    localparam int MANT_BITS     = 60;
    localparam int OUT_MANT_W    = 60;
    localparam int CNT_W         = 6;
    localparam int CHAR_W        = 7;
    localparam int IN_CHAR_W     = 8;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int PROD_W        = MANT_BITS + 4;

    localparam logic [MODE_W-1:0] MODE_UNSIGNED    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SIGNED      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INTEGER     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INTEGER_ALT = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RESET       = MODE_UNSIGNED;
    localparam int                MODE_INT_BIT     = 1;

    localparam logic [CHAR_W-1:0] CH_OPEN  = 7'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 7'h29;
    localparam logic [CHAR_W-1:0] CH_COMMA = 7'h2C;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_ILLEGAL  = 2'd1,
        ST_LIMIT    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic                 in_brackets;
        logic [CNT_W-1:0]     char_cnt;
        logic [MANT_BITS-1:0] acc;
        logic [CNT_W-1:0]     frac_cnt;
        logic                 point;
        logic                 minus;
    } t_parse_state;

    typedef struct packed {
        logic                  emit;
        logic [OUT_MANT_W-1:0] mantissa;
        logic [CNT_W-1:0]      frac_digits;
        logic                  negative;
        t_status               status;
    } t_step_out;

endpackage

FILE: design/bdp_step.sv
// Per-byte parse step: next parser state and the optional result.
// Depends on bdp_pkg for the state and result types.
module bdp_step (
    input  logic [bdp_pkg::MODE_W-1:0] i_mode,
    input  logic [bdp_pkg::CHAR_W-1:0] i_char,
    input  bdp_pkg::t_parse_state      i_state,
    output bdp_pkg::t_parse_state      o_state,
    output bdp_pkg::t_step_out         o_res
);

    logic                           int_mode;
    logic                           signed_mode;
    logic                           is_term;
    logic                           is_digit;
    logic [3:0]                     digit;
    logic [bdp_pkg::PROD_W-1:0]     prod;
    logic                           ovf;
    logic [bdp_pkg::CNT_W-1:0]      cnt_inc;
    bdp_pkg::t_status               st;
    bdp_pkg::t_parse_state          work;

    assign int_mode    = i_mode[bdp_pkg::MODE_INT_BIT];
    assign signed_mode = (i_mode == bdp_pkg::MODE_SIGNED);
    assign is_term     = (i_char == bdp_pkg::CH_CLOSE) ||
                         ((i_char == bdp_pkg::CH_COMMA) && !int_mode);
    assign is_digit    = (i_char >= bdp_pkg::CH_ZERO) && (i_char <= bdp_pkg::CH_NINE);
    assign digit       = 4'(i_char - bdp_pkg::CH_ZERO);

    // acc * 10 + digit never needs more than four extra bits.
    assign prod = (bdp_pkg::PROD_W'(i_state.acc) << 3) +
                  (bdp_pkg::PROD_W'(i_state.acc) << 1) +
                  bdp_pkg::PROD_W'(digit);
    assign ovf  = (prod[bdp_pkg::PROD_W-1:bdp_pkg::MANT_BITS] != '0);
    assign cnt_inc = i_state.char_cnt + bdp_pkg::CNT_W'(1);

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        work    = i_state;
        st      = bdp_pkg::ST_OK;

        if (!i_state.in_brackets) begin
            if (i_char == bdp_pkg::CH_OPEN) begin
                o_state             = '0;
                o_state.in_brackets = 1'b1;
                o_state.char_cnt    = bdp_pkg::CNT_W'(1);
            end
        end else if (is_term) begin
            o_res.emit        = 1'b1;
            o_res.mantissa    = bdp_pkg::OUT_MANT_W'(i_state.acc);
            o_res.frac_digits = i_state.frac_cnt;
            o_res.negative    = i_state.minus;
            o_res.status      = bdp_pkg::ST_OK;
            o_state           = '0;
        end else begin
            if (is_digit) begin
                if (ovf) begin
                    st = bdp_pkg::ST_OVERFLOW;
                end else begin
                    work.acc = prod[bdp_pkg::MANT_BITS-1:0];
                    if (i_state.point && (i_state.frac_cnt != '1)) begin
                        work.frac_cnt = i_state.frac_cnt + bdp_pkg::CNT_W'(1);
                    end
                end
            end else if ((i_char == bdp_pkg::CH_POINT) && !int_mode) begin
                work.point    = 1'b1;
                work.frac_cnt = '0;
            end else if ((i_char == bdp_pkg::CH_MINUS) && signed_mode) begin
                work.minus = 1'b1;
            end else begin
                st = bdp_pkg::ST_ILLEGAL;
            end

            if (st != bdp_pkg::ST_OK) begin
                o_res.emit   = 1'b1;
                o_res.status = st;
                o_state      = '0;
            end else if (cnt_inc >= bdp_pkg::CNT_W'(bdp_pkg::MAX_CHARS)) begin
                o_res.emit   = 1'b1;
                o_res.status = bdp_pkg::ST_LIMIT;
                o_state      = '0;
            end else begin
                o_state          = work;
                o_state.char_cnt = cnt_inc;
            end
        end
    end

endmodule

FILE: design/bracketed_decimal_parser_core.sv
// Top level of the bracketed decimal parser: handshakes, registers, checks.
// Depends on bdp_pkg, bdp_step and bracketed_decimal_parser_core_defines.svh.
//
// The core takes one received byte per transfer and accepts a new byte in
// every clock cycle. Bit 7 of each byte is dropped. Bytes are skipped until
// an open bracket; after it, digits build an exact 60-bit mantissa, a point
// restarts the count of fraction digits, and in signed mode a minus sign
// marks the value negative. A close bracket, or a comma in the two decimal
// modes, ends the number and produces one result transfer carrying the
// mantissa, the fraction digit count, the sign and an ok status. An illegal
// byte, a mantissa that would overflow, or a number reaching 40 bytes
// (bracket included) produces an error result instead, with zero payload,
// and the core goes back to hunting for an open bracket. A byte flows through
// an input register and a result register. The whole parse step (a multiply
// by ten done as two shifts and an add, plus the overflow check) sits between
// those two registers. The input side stalls only when the result register
// is full, its consumer stalls, and the waiting byte would produce another
// result.
// The mode register is written through i_cfg_wr_en and i_cfg_wr_data and
// must only be changed while no transfer is in flight.
`include "bracketed_decimal_parser_core_defines.svh"

module bracketed_decimal_parser_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bdp_pkg::MODE_W-1:0]        i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bdp_pkg::IN_CHAR_W-1:0]     i_char_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bdp_pkg::OUT_MANT_W-1:0]    o_mantissa,
    output logic [bdp_pkg::CNT_W-1:0]         o_frac_digits,
    output logic                              o_negative,
    output logic [bdp_pkg::STATUS_W-1:0]      o_status
);

    // Configuration and parser state.
    logic [bdp_pkg::MODE_W-1:0]     r_mode;
    bdp_pkg::t_parse_state          r_state;
    bdp_pkg::t_parse_state          n_state;

    // Input register holding the masked byte.
    logic                           r_in_valid;
    logic [bdp_pkg::CHAR_W-1:0]     r_char;

    // Result register.
    logic                           r_out_valid;
    logic [bdp_pkg::OUT_MANT_W-1:0] r_mant;
    logic [bdp_pkg::CNT_W-1:0]      r_frac;
    logic                           r_neg;
    bdp_pkg::t_status               r_status;

    bdp_pkg::t_step_out             step_res;
    logic                           advance;
    logic                           in_accept;

    bdp_step u_step (
        .i_mode  (r_mode),
        .i_char  (r_char),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (step_res)
    );

    // A byte leaves the input register whenever its result, if any, has room.
    assign advance    = r_in_valid && (!step_res.emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= bdp_pkg::MODE_RESET;
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end

            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_state <= n_state;
            end

            if (advance && step_res.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_char <= i_char_in[bdp_pkg::CHAR_W-1:0];
        end
        if (advance && step_res.emit) begin
            r_mant   <= step_res.mantissa;
            r_frac   <= step_res.frac_digits;
            r_neg    <= step_res.negative;
            r_status <= step_res.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mantissa    = r_mant;
    assign o_frac_digits = r_frac;
    assign o_negative    = r_neg;
    assign o_status      = r_status;

    // Error results carry a zero payload.
    `BDP_ASSERT(a_err_payload_zero, i_clk, i_rst_n, (r_out_valid && (r_status != bdp_pkg::ST_OK)) |-> ((r_mant == '0) && (r_frac == '0) && !r_neg))

    // While hunting, the number state stays cleared.
    `BDP_ASSERT(a_hunt_clear, i_clk, i_rst_n, !r_state.in_brackets |-> ((r_state.acc == '0) && (r_state.frac_cnt == '0) && !r_state.point && !r_state.minus))

    // A delivered fraction count is always below the byte limit.
    `BDP_ASSERT(a_frac_bound, i_clk, i_rst_n, r_out_valid |-> (r_frac < bdp_pkg::CNT_W'(bdp_pkg::MAX_CHARS)))

    // A held byte stays in the input register unchanged.
    `BDP_ASSERT(a_in_hold, i_clk, i_rst_n, (r_in_valid && !advance) |=> (r_in_valid && $stable(r_char)))

endmodule
